### design/bnpm_pkg.sv
// shared constants, types and codes of the boundary node plane marker
`default_nettype none

package bnpm_pkg;

   localparam int unsigned GHOST_LAYERS = 2;
   localparam int unsigned DIV_WIDTH    = 32;
   localparam int unsigned ROW_WIDTH    = 16;
   localparam int unsigned COORD_WIDTH  = DIV_WIDTH + 2;
   localparam int unsigned ADDR_WIDTH   = 36;
   localparam int unsigned EXTENT_WIDTH = 13;
   localparam int unsigned CNT_WIDTH    = $clog2(DIV_WIDTH);

   typedef logic [2:0] status_type;
   localparam status_type ST_MARKED     = 3'd0;
   localparam status_type ST_SKIP_UNDER = 3'd1;
   localparam status_type ST_SKIP_OVER  = 3'd2;
   localparam status_type ST_NEG_NORMAL = 3'd3;
   localparam status_type ST_MISMATCH   = 3'd4;
   localparam status_type ST_UNDERSHOOT = 3'd5;
   localparam status_type ST_OVERSHOOT  = 3'd6;
   localparam status_type ST_ABORTED    = 3'd7;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type REG_ROW_STRIDE   = 3'd0;
   localparam csr_index_type REG_PLANE_STRIDE = 3'd1;
   localparam csr_index_type REG_EXTENT_I     = 3'd2;
   localparam csr_index_type REG_EXTENT_J     = 3'd3;
   localparam csr_index_type REG_EXTENT_K     = 3'd4;
   localparam csr_index_type REG_NORMAL_AXIS  = 3'd5;
   localparam csr_index_type REG_BOUNDARY_ID  = 3'd6;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_I       = 2'd0;
   localparam axis_type AXIS_J       = 2'd1;
   localparam axis_type AXIS_K       = 2'd2;
   localparam axis_type AXIS_K_ALIAS = 2'd3;

   typedef struct packed {
      logic [ROW_WIDTH-1:0]    row_stride;
      logic [DIV_WIDTH-1:0]    plane_stride;
      logic [EXTENT_WIDTH-1:0] extent_i;
      logic [EXTENT_WIDTH-1:0] extent_j;
      logic [EXTENT_WIDTH-1:0] extent_k;
      axis_type                normal_axis;
      logic signed [31:0]      boundary_id;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_WIDTH-1:0] dividend;
      logic [DIV_WIDTH-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_WIDTH-1:0] quotient;
      logic [DIV_WIDTH-1:0] remainder;
   } div_res_type;

endpackage

`default_nettype wire

### design/bnpm_if.sv
// valid/ready channel interfaces for node items and result items
`default_nettype none

interface bnpm_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] node_index;
   logic        first_of_run;
   logic        last_of_run;

   modport source (output valid, input ready, output node_index, output first_of_run,
                   output last_of_run);
   modport sink (input valid, output ready, input node_index, input first_of_run,
                 input last_of_run);
endinterface

interface bnpm_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic               write_enable;
   logic [35:0]        table_address;
   logic signed [31:0] write_value;
   logic [31:0]        plane_index;
   logic               run_done;

   modport source (output valid, input ready, output status, output write_enable,
                   output table_address, output write_value, output plane_index,
                   output run_done);
   modport sink (input valid, output ready, input status, input write_enable,
                 input table_address, input write_value, input plane_index,
                 input run_done);
endinterface

`default_nettype wire

### design/bnpm_csr.sv
// configuration registers with zero stride and axis alias folding
`default_nettype none

module bnpm_csr
   import bnpm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write_enable,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0]   csr_data,
   output cfg_type            cfg
);

   logic [ROW_WIDTH-1:0]    row_stride_ff;
   logic [DIV_WIDTH-1:0]    plane_stride_ff;
   logic [EXTENT_WIDTH-1:0] extent_i_ff;
   logic [EXTENT_WIDTH-1:0] extent_j_ff;
   logic [EXTENT_WIDTH-1:0] extent_k_ff;
   axis_type                normal_axis_ff;
   logic signed [31:0]      boundary_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_stride_ff   <= ROW_WIDTH'(1);
         plane_stride_ff <= DIV_WIDTH'(1);
         extent_i_ff     <= EXTENT_WIDTH'(1);
         extent_j_ff     <= EXTENT_WIDTH'(1);
         extent_k_ff     <= EXTENT_WIDTH'(1);
         normal_axis_ff  <= AXIS_I;
         boundary_id_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ROW_STRIDE:   row_stride_ff   <= csr_data[ROW_WIDTH-1:0];
            REG_PLANE_STRIDE: plane_stride_ff <= csr_data[DIV_WIDTH-1:0];
            REG_EXTENT_I:     extent_i_ff     <= csr_data[EXTENT_WIDTH-1:0];
            REG_EXTENT_J:     extent_j_ff     <= csr_data[EXTENT_WIDTH-1:0];
            REG_EXTENT_K:     extent_k_ff     <= csr_data[EXTENT_WIDTH-1:0];
            REG_NORMAL_AXIS:  normal_axis_ff  <= csr_data[1:0];
            REG_BOUNDARY_ID:  boundary_id_ff  <= signed'(csr_data);
            default: ;
         endcase
      end
   end

   // a zero stride divides as one, axis three means k
   always_comb begin
      cfg.row_stride   = (row_stride_ff == '0) ? ROW_WIDTH'(1) : row_stride_ff;
      cfg.plane_stride = (plane_stride_ff == '0) ? DIV_WIDTH'(1) : plane_stride_ff;
      cfg.extent_i     = extent_i_ff;
      cfg.extent_j     = extent_j_ff;
      cfg.extent_k     = extent_k_ff;
      cfg.normal_axis  = (normal_axis_ff == AXIS_K_ALIAS) ? AXIS_K : normal_axis_ff;
      cfg.boundary_id  = boundary_id_ff;
   end

endmodule

`default_nettype wire

### design/bnpm_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module bnpm_div
   import bnpm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_cmd_type cmd,
   output div_res_type      res
);

   logic [DIV_WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_WIDTH-1:0] quo_ff, quo_in;
   logic [DIV_WIDTH-1:0] divisor_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [DIV_WIDTH:0]   rem_sh;
   logic [DIV_WIDTH+1:0] diff;
   logic                 fit;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_WIDTH-1]};
      diff   = {1'b0, rem_sh} - {2'b00, divisor_ff};
      fit    = !diff[DIV_WIDTH+1];
      rem_in = fit ? diff[DIV_WIDTH-1:0] : rem_sh[DIV_WIDTH-1:0];
      quo_in = {quo_ff[DIV_WIDTH-2:0], fit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_WIDTH'(DIV_WIDTH - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_WIDTH'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff     <= '0;
         quo_ff     <= cmd.dividend;
         divisor_ff <= cmd.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign res.done      = done_ff;
   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;

endmodule

`default_nettype wire

### design/boundary_node_plane_marker.sv
// top level: splits ghosted node indexes, checks run planes, forms table writes
//
//   channel   direction  handshake               payload
//   req_bus   in         valid/ready             node_index, first_of_run, last_of_run
//   rsp_bus   out        valid/ready             status, write_enable, table_address,
//                                                write_value, plane_index, run_done
//   csr_*     in         csr_write_enable only   csr_index, csr_data
//
// an item runs three divisions on one shared divider (node by plane
// stride, plane remainder by row stride, node by row stride), then the plane
// check and, for a marked node, the address steps; an aborted item skips to done
// req_bus.ready is high only while the sequencer is idle; a result parked in
// the output register does not block the next item, the next result waits
// synchronous active-high reset clears the sequencer, run flag, run plane and
// configuration to their reset values
`default_nettype none

module boundary_node_plane_marker
   import bnpm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   bnpm_req_if.sink           req_bus,
   bnpm_rsp_if.source         rsp_bus,
   input  wire logic          csr_write_enable,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0]   csr_data
);

   // sequencer codes
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIVP  = 3'd1;  // node by plane stride
   localparam logic [2:0] S_DIVJ  = 3'd2;  // plane remainder by row stride
   localparam logic [2:0] S_DIVI  = 3'd3;  // node by row stride
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_MULK  = 3'd5;
   localparam logic [2:0] S_MULJ  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic signed [COORD_WIDTH-1:0] GHOST  = COORD_WIDTH'(GHOST_LAYERS);
   localparam logic signed [COORD_WIDTH-1:0] MINUS1 = -COORD_WIDTH'(1);

   cfg_type     cfg;
   div_cmd_type div_cmd;
   div_res_type div_res;

   logic [2:0]                     state_ff, state_in;
   logic [DIV_WIDTH-1:0]           node_ff;
   logic                           first_ff;
   logic                           last_ff;
   status_type                     status_ff, status_in;
   logic signed [COORD_WIDTH-1:0]  ci_ff, cj_ff, ck_ff;
   logic [ADDR_WIDTH-1:0]          prod_ff, prod_in;
   logic [31:0]                    run_plane_ff, run_plane_in;
   logic                           run_error_ff, run_error_in;

   logic                           rsp_valid_ff;
   status_type                     rsp_status_ff;
   logic                           rsp_we_ff;
   logic [ADDR_WIDTH-1:0]          rsp_addr_ff;
   logic signed [31:0]             rsp_value_ff;
   logic [31:0]                    rsp_plane_ff;
   logic                           rsp_done_ff;

   logic                           accept;
   logic                           abort;
   logic                           rsp_free;

   // coordinate selection for the check
   logic signed [COORD_WIDTH-1:0]  n_c, p0, p1, x0, x1;
   status_type                     check_status;

   // one address multiplier shared by both address steps
   logic [ADDR_WIDTH-1:0]          mul_a;
   logic [EXTENT_WIDTH-1:0]        mul_b;
   logic [ADDR_WIDTH-1:0]          mul_p;

   bnpm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   bnpm_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   // a run with a sticky error aborts unless this item starts a new run
   assign abort         = run_error_ff && !req_bus.first_of_run;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // divider operand steering
   always_comb begin
      div_cmd.start    = 1'b0;
      div_cmd.dividend = node_ff;
      div_cmd.divisor  = {{(DIV_WIDTH-ROW_WIDTH){1'b0}}, cfg.row_stride};
      unique case (state_ff)
         S_IDLE: begin
            div_cmd.start    = accept && !abort;
            div_cmd.dividend = req_bus.node_index;
            div_cmd.divisor  = cfg.plane_stride;
         end
         S_DIVP: begin
            div_cmd.start    = div_res.done;
            div_cmd.dividend = div_res.remainder;
         end
         S_DIVJ: begin
            div_cmd.start    = div_res.done;
         end
         default: ;
      endcase
   end

   // plane and in-plane checks in priority order
   always_comb begin
      unique case (cfg.normal_axis)
         AXIS_I: begin
            n_c = ci_ff;
            p0  = cj_ff;
            p1  = ck_ff;
            x0  = COORD_WIDTH'(cfg.extent_j);
            x1  = COORD_WIDTH'(cfg.extent_k);
         end
         AXIS_J: begin
            n_c = cj_ff;
            p0  = ci_ff;
            p1  = ck_ff;
            x0  = COORD_WIDTH'(cfg.extent_i);
            x1  = COORD_WIDTH'(cfg.extent_k);
         end
         default: begin
            n_c = ck_ff;
            p0  = ci_ff;
            p1  = cj_ff;
            x0  = COORD_WIDTH'(cfg.extent_i);
            x1  = COORD_WIDTH'(cfg.extent_j);
         end
      endcase

      priority if (n_c[COORD_WIDTH-1]) begin
         check_status = ST_NEG_NORMAL;
      end else if (!first_ff && (n_c[31:0] != run_plane_ff)) begin
         check_status = ST_MISMATCH;
      end else if (p0[COORD_WIDTH-1] || p1[COORD_WIDTH-1]) begin
         check_status = (p0 < MINUS1 || p1 < MINUS1) ? ST_UNDERSHOOT : ST_SKIP_UNDER;
      end else if (p0 >= x0 || p1 >= x1) begin
         check_status = (p0 > x0 || p1 > x1) ? ST_OVERSHOOT : ST_SKIP_OVER;
      end else begin
         check_status = ST_MARKED;
      end
   end

   // extent_j * k first, then extent_i * (j + extent_j * k); wraps at 36 bits
   always_comb begin
      if (state_ff == S_MULJ) begin
         mul_a = {2'b00, cj_ff} + prod_ff;
         mul_b = cfg.extent_i;
      end else begin
         mul_a = {2'b00, ck_ff};
         mul_b = cfg.extent_j;
      end
      mul_p = ADDR_WIDTH'(mul_a * {{(ADDR_WIDTH-EXTENT_WIDTH){1'b0}}, mul_b});
   end

   // sequencer next state and run bookkeeping
   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      prod_in      = prod_ff;
      run_plane_in = run_plane_ff;
      run_error_in = run_error_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_bus.first_of_run) begin
                  run_error_in = 1'b0;
               end
               if (abort) begin
                  status_in = ST_ABORTED;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_DIVP;
               end
            end
         end
         S_DIVP: begin
            if (div_res.done) begin
               state_in = S_DIVJ;
            end
         end
         S_DIVJ: begin
            if (div_res.done) begin
               state_in = S_DIVI;
            end
         end
         S_DIVI: begin
            if (div_res.done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in = check_status;
            if (first_ff && !n_c[COORD_WIDTH-1]) begin
               run_plane_in = n_c[31:0];
            end
            if (check_status == ST_NEG_NORMAL || check_status == ST_MISMATCH ||
                check_status == ST_UNDERSHOOT || check_status == ST_OVERSHOOT) begin
               run_error_in = 1'b1;
            end
            state_in = (check_status == ST_MARKED) ? S_MULK : S_DONE;
         end
         S_MULK: begin
            prod_in  = mul_p;
            state_in = S_MULJ;
         end
         S_MULJ: begin
            prod_in  = mul_p;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_plane_ff <= '0;
         run_error_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_plane_ff <= run_plane_in;
         run_error_ff <= run_error_in;
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item payload and coordinates
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      prod_ff   <= prod_in;
      if (accept) begin
         node_ff  <= req_bus.node_index;
         first_ff <= req_bus.first_of_run;
         last_ff  <= req_bus.last_of_run;
      end
      if (div_res.done) begin
         unique case (state_ff)
            S_DIVP:  ck_ff <= {2'b00, div_res.quotient} - GHOST;
            S_DIVJ:  cj_ff <= {2'b00, div_res.quotient} - GHOST;
            S_DIVI:  ci_ff <= {2'b00, div_res.remainder} - GHOST;
            default: ;
         endcase
      end
   end

   // output register, loaded once the previous result is taken
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && rsp_free) begin
         rsp_status_ff <= status_ff;
         rsp_plane_ff  <= run_plane_ff;
         rsp_done_ff   <= last_ff;
         if (status_ff == ST_MARKED) begin
            rsp_we_ff    <= 1'b1;
            rsp_addr_ff  <= {2'b00, ci_ff} + prod_ff;
            rsp_value_ff <= cfg.boundary_id;
         end else begin
            rsp_we_ff    <= 1'b0;
            rsp_addr_ff  <= '0;
            rsp_value_ff <= '0;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.write_enable  = rsp_we_ff;
   assign rsp_bus.table_address = rsp_addr_ff;
   assign rsp_bus.write_value   = rsp_value_ff;
   assign rsp_bus.plane_index   = rsp_plane_ff;
   assign rsp_bus.run_done      = rsp_done_ff;

endmodule

`default_nettype wire

### test/tb_boundary_node_plane_marker.sv
// testbench of the boundary node plane marker: runs of mesh nodes checked against a predictor
`default_nettype none

module tb_boundary_node_plane_marker;
   timeunit 1ns;
   timeprecision 1ps;

   import bnpm_pkg::*;

   localparam longint GHOSTS = GHOST_LAYERS;

   // one node item as offered on the request channel
   typedef struct packed {
      logic [31:0] node_index;
      logic        first_of_run;
      logic        last_of_run;
   } node_item_type;

   // one table write item as expected on the result channel
   typedef struct packed {
      status_type  status;
      logic        write_enable;
      logic [35:0] table_address;
      logic [31:0] write_value;
      logic [31:0] plane_index;
      logic        run_done;
   } table_write_type;

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   logic [31:0]   csr_data;

   bnpm_req_if req_bus ();
   bnpm_rsp_if rsp_bus ();

   boundary_node_plane_marker uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // shadow of the mesh registers and of the run state
   cfg_type     mesh_cfg;
   logic [31:0] plane_seen;
   logic        run_broken;

   node_item_type   node_queue[$];    // nodes not yet put on the bus
   table_write_type table_writes[$];  // predicted results, oldest first
   node_item_type   offered;          // node currently on the bus

   int errors;
   int phase_no;
   logic steady;                   // no idling on either side while set
   int hold_requests;
   int hold_served;
   int hold_left;

   cfg_type shape;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // overall time limit
   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------- mesh helpers

   function automatic longint eff_stride(input longint s);
      return (s == 0) ? 1 : s;
   endfunction

   function automatic longint extent_along(input int a);
      case (a)
         int'(AXIS_I): return longint'(mesh_cfg.extent_i);
         int'(AXIS_J): return longint'(mesh_cfg.extent_j);
         default:      return longint'(mesh_cfg.extent_k);
      endcase
   endfunction

   // normal axis (the alias folds onto k) and the two in-plane axes
   function automatic void plane_axes(output int ax, output int a0, output int a1);
      ax = (mesh_cfg.normal_axis == AXIS_K_ALIAS) ? int'(AXIS_K) : int'(mesh_cfg.normal_axis);
      a0 = (ax == int'(AXIS_I)) ? int'(AXIS_J) : int'(AXIS_I);
      a1 = 3 ^ ax ^ a0;
   endfunction

   // ghosted linear index of a node given as normal and in-plane coordinates
   function automatic logic [31:0] node_in_plane(input longint n, input longint p0,
                                                 input longint p1);
      longint c[3];
      int     ax, a0, a1;
      longint rs, ps;
      plane_axes(ax, a0, a1);
      c[ax] = n;
      c[a0] = p0;
      c[a1] = p1;
      rs = eff_stride(longint'(mesh_cfg.row_stride));
      ps = eff_stride(longint'(mesh_cfg.plane_stride));
      return 32'((c[0] + GHOSTS) + rs * (c[1] + GHOSTS) + ps * (c[2] + GHOSTS));
   endfunction

   // ---------------------------------------------------------------- predictor

   // decomposes one node, checks the run plane and forms the table write
   function automatic table_write_type predict_mark(input node_item_type it);
      table_write_type r;
      longint          node, rs, ps;
      longint          c[3];
      longint          n, p0, p1, x0, x1;
      int              ax, a0, a1;
      r = '0;
      r.status = ST_MARKED;
      r.run_done = it.last_of_run;
      if (it.first_of_run) run_broken = 1'b0;
      if (run_broken) begin
         r.status = ST_ABORTED;
      end else begin
         node = longint'(it.node_index);
         rs = eff_stride(longint'(mesh_cfg.row_stride));
         ps = eff_stride(longint'(mesh_cfg.plane_stride));
         plane_axes(ax, a0, a1);
         c[0] = (node % rs) - GHOSTS;
         c[1] = ((node % ps) / rs) - GHOSTS;
         c[2] = (node / ps) - GHOSTS;
         n = c[ax];
         p0 = c[a0];
         p1 = c[a1];
         x0 = extent_along(a0);
         x1 = extent_along(a1);
         if (n < 0) begin
            r.status = ST_NEG_NORMAL;
         end else if (!it.first_of_run && n != longint'(plane_seen)) begin
            r.status = ST_MISMATCH;
         end else begin
            if (it.first_of_run) plane_seen = n[31:0];
            if (p0 < 0 || p1 < 0) begin
               r.status = (p0 < -1 || p1 < -1) ? ST_UNDERSHOOT : ST_SKIP_UNDER;
            end else if (p0 >= x0 || p1 >= x1) begin
               r.status = (p0 > x0 || p1 > x1) ? ST_OVERSHOOT : ST_SKIP_OVER;
            end
         end
         if (r.status >= ST_NEG_NORMAL) begin
            run_broken = 1'b1;
         end else if (r.status == ST_MARKED) begin
            r.write_enable = 1'b1;
            r.table_address = 36'(c[0] + extent_along(0) * (c[1] + extent_along(1) * c[2]));
            r.write_value = mesh_cfg.boundary_id;
         end
      end
      r.plane_index = plane_seen;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void field_check(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_table_write(input table_write_type got);
      table_write_type want;
      if (table_writes.size() == 0) begin
         $display("%0t unexpected result: expected none actual %h", $realtime, got);
         errors++;
      end else begin
         want = table_writes.pop_front();
         field_check("status", want.status, got.status);
         field_check("write_enable", want.write_enable, got.write_enable);
         field_check("table_address", want.table_address, got.table_address);
         field_check("write_value", want.write_value, got.write_value);
         field_check("plane_index", want.plane_index, got.plane_index);
         field_check("run_done", want.run_done, got.run_done);
      end
   endfunction

   // ---------------------------------------------------------------- driver

   // prediction happens at the edge that accepts the node, the next node is
   // offered only once the bus is free
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) table_writes.push_back(predict_mark(offered));
         if (!req_bus.valid || req_bus.ready) begin
            if (node_queue.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
               offered = node_queue.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.node_index <= offered.node_index;
               req_bus.first_of_run <= offered.first_of_run;
               req_bus.last_of_run <= offered.last_of_run;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // a hold-off request keeps ready low for a long stretch so the block fills up
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_table_write('{rsp_bus.status, rsp_bus.write_enable, rsp_bus.table_address,
                                rsp_bus.write_value, rsp_bus.plane_index, rsp_bus.run_done});
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (hold_served != hold_requests) begin
            hold_served = hold_served + 1;
            hold_left = 700;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || $urandom_range(99) >= 34;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   function automatic void push_node(input logic [31:0] node, input logic first,
                                     input logic last);
      node_queue.push_back('{node, first, last});
   endfunction

   function automatic void push_plane(input longint n, input longint p0, input longint p1,
                                      input logic first, input logic last);
      push_node(node_in_plane(n, p0, p1), first, last);
   endfunction

   // registers for a well-formed ghosted mesh of the given real extents
   function automatic cfg_type mesh_shape(input int ei, input int ej, input int ek,
                                          input axis_type axis, input logic [31:0] id);
      cfg_type c;
      c.row_stride = 16'(ei + 4);
      c.plane_stride = 32'((ei + 4) * (ej + 4));
      c.extent_i = 13'(ei);
      c.extent_j = 13'(ej);
      c.extent_k = 13'(ek);
      c.normal_axis = axis;
      c.boundary_id = id;
      return c;
   endfunction

   // mostly small meshes, now and then a large one
   function automatic int pick_extent();
      return ($urandom_range(4) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 10);
   endfunction

   function automatic cfg_type random_shape();
      return mesh_shape(pick_extent(), pick_extent(), pick_extent(),
                        axis_type'($urandom_range(3)), $urandom);
   endfunction

   // in-plane coordinate: mostly inside, sometimes on or past an edge
   function automatic longint pick_coord(input longint lim);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 82) return longint'($urandom_range(0, 32'(lim - 1)));
      if (roll < 88) return -1;
      if (roll < 94) return lim;
      if (roll < 97) return -2;
      return lim + 1;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
   endtask

   // called at a clock edge while the block is idle
   task automatic program_mesh(input cfg_type c);
      write_reg(REG_ROW_STRIDE, 32'(c.row_stride));
      write_reg(REG_PLANE_STRIDE, c.plane_stride);
      write_reg(REG_EXTENT_I, 32'(c.extent_i));
      write_reg(REG_EXTENT_J, 32'(c.extent_j));
      write_reg(REG_EXTENT_K, 32'(c.extent_k));
      write_reg(REG_NORMAL_AXIS, 32'(c.normal_axis));
      write_reg(REG_BOUNDARY_ID, c.boundary_id);
      csr_write_enable <= 1'b0;
      mesh_cfg = c;
   endtask

   // runs of one plane with random content, a few broken runs and stray nodes
   task automatic fill_runs(input int count);
      int     made, len, k, ax, a0, a1;
      longint pn, n;
      made = 0;
      plane_axes(ax, a0, a1);
      while (made < count) begin
         if ($urandom_range(99) < 6) begin
            push_node($urandom, $urandom_range(1) == 1, $urandom_range(1) == 1);
            made++;
         end else begin
            len = $urandom_range(1, 8);
            pn = longint'($urandom_range(0, 32'(extent_along(ax) - 1)));
            for (k = 0; k < len; k++) begin
               n = pn;
               case ($urandom_range(49))
                  0: n = pn + 1;
                  1: n = pn - 1;
                  2: n = -1;
                  default: ;
               endcase
               push_plane(n, pick_coord(extent_along(a0)), pick_coord(extent_along(a1)),
                          k == 0 && $urandom_range(19) != 0, k == len - 1);
            end
            made += len;
         end
      end
   endtask

   // wait until every node is taken and every result has come back
   task automatic drain();
      while (node_queue.size() != 0 || req_bus.valid || table_writes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.node_index = '0;
      req_bus.first_of_run = 1'b0;
      req_bus.last_of_run = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = REG_ROW_STRIDE;
      csr_data = '0;
      errors = 0;
      steady = 1'b0;
      hold_requests = 0;
      hold_served = 0;
      hold_left = 0;
      mesh_cfg = mesh_shape(1, 1, 1, AXIS_I, 32'h0);
      mesh_cfg.row_stride = 16'd1;
      mesh_cfg.plane_stride = 32'd1;
      plane_seen = '0;
      run_broken = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset registers: no run start yet, every node has a negative i
      push_node(32'h0, 1'b0, 1'b0);
      push_node(32'hFFFF_FFFF, 1'b1, 1'b0);
      push_node(32'h5, 1'b0, 1'b1);
      drain();

      // small mesh, plane normal to k: every status in turn
      program_mesh(mesh_shape(3, 2, 3, AXIS_K, 32'sd77));
      push_plane(1, 0, 0, 1'b1, 1'b0);
      push_plane(1, -1, 0, 1'b0, 1'b0);
      push_plane(1, 3, 1, 1'b0, 1'b0);
      push_plane(1, 2, 1, 1'b0, 1'b1);
      push_plane(2, 1, 1, 1'b1, 1'b0);
      push_plane(0, 1, 1, 1'b0, 1'b0);   // plane mismatch
      push_plane(2, 0, 0, 1'b0, 1'b0);   // aborted run
      push_plane(2, 0, 0, 1'b0, 1'b1);
      push_plane(0, 0, -2, 1'b1, 1'b1);  // undershoot
      push_plane(0, 4, 0, 1'b1, 1'b0);   // overshoot
      push_plane(0, 0, 0, 1'b0, 1'b1);
      push_plane(-1, 0, 0, 1'b1, 1'b1);  // negative normal
      push_plane(5, 2, 1, 1'b1, 1'b1);   // normal coordinate past its extent
      drain();

      // zero strides act as one, axis alias acts as k
      shape = mesh_shape(1, 1, 1, AXIS_K_ALIAS, 32'h7FFF_FFFF);
      shape.row_stride = '0;
      shape.plane_stride = '0;
      program_mesh(shape);
      push_node(32'd2, 1'b1, 1'b0);
      push_node(32'd1, 1'b1, 1'b1);
      drain();

      // same mesh normal to i, then normal to j
      program_mesh(mesh_shape(3, 2, 3, AXIS_I, 32'hFFFF_FFF3));
      push_plane(2, 0, 0, 1'b1, 1'b0);
      push_plane(2, 1, 2, 1'b0, 1'b0);
      push_plane(2, 2, 0, 1'b0, 1'b0);
      push_plane(2, 1, 3, 1'b0, 1'b0);
      push_plane(2, 0, -1, 1'b0, 1'b1);
      drain();
      program_mesh(mesh_shape(3, 2, 3, AXIS_J, 32'hFFFF_FFF5));
      push_plane(1, 0, 2, 1'b1, 1'b0);
      push_plane(1, 2, 1, 1'b0, 1'b1);
      drain();

      // random phases: largest and smallest meshes, random shapes, raw strides
      for (phase_no = 0; phase_no < 9; phase_no++) begin
         case (phase_no)
            0: begin
               shape = mesh_shape(4096, 4096, 4096, AXIS_I, 32'h8000_0000);
               shape.row_stride = 16'hFFFF;
               shape.plane_stride = 32'hFFFF_FFFF;
            end
            1: shape = mesh_shape(1, 1, 1, AXIS_K, 32'h7FFF_FFFF);
            7: begin
               shape = random_shape();
               shape.row_stride = 16'($urandom);
               shape.plane_stride = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
            end
            default: shape = random_shape();
         endcase
         program_mesh(shape);
         steady <= (phase_no == 3);
         if (phase_no == 5) hold_requests <= hold_requests + 1;
         fill_runs(56);
         drain();
      end
      steady <= 1'b0;

      repeat (150) @(posedge clock);
      if (errors == 0 && table_writes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
